>>> rtl/kvt_pkg.sv
// Shared types, codes and helper function of the keyed value table.
package kvt_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_EMPTY_KEY = 2'd3;

  // Widths of the request and result fields.
  localparam int unsigned KEY_FIELD_W = 64;
  localparam int unsigned VAL_FIELD_W = 32;

  // One request as it arrives on the input channel.
  typedef struct packed {
    logic [1:0]             opcode;
    logic [KEY_FIELD_W-1:0] key;
    logic [VAL_FIELD_W-1:0] value;
  } kvt_req_t;

  // One result as it leaves on the output channel.
  typedef struct packed {
    logic [1:0]             status;
    logic [VAL_FIELD_W-1:0] value_res;
  } kvt_res_t;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } kvt_state_t;

  // Access command from the sequencer to the entry memories.
  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic val_we;
  } kvt_mem_cmd_t;

  // Keep the key bytes before the first zero byte, within nbytes; clear the rest.
  function automatic logic [KEY_FIELD_W-1:0] normalize_key(
    input logic [KEY_FIELD_W-1:0] raw,
    input int unsigned            nbytes
  );
    logic [KEY_FIELD_W-1:0] result;
    logic                   ended;
    result = '0;
    ended  = 1'b0;
    for (int b = 0; b < KEY_FIELD_W / 8; b++) begin
      if (b >= nbytes || raw[8*b +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        result[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return result;
  endfunction

endpackage

>>> rtl/keyed_value_table_unit.sv
// Top level of the exact-match keyed value table.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid, in_stall   in_req  (opcode, key, value)
//   out_     output     out_valid, out_stall out_res (status, value_res)
//
// A set, get or delete scans every entry after acceptance and then commits the
// update and presents the result: the key and value memories have one read
// port, so the scan reads one entry per cycle; the commit waits while the output
// register is stalled. An empty key or an unused opcode skips the scan.
// One request is in flight at a time; a result waiting in the output register
// does not block acceptance of the next request, only its commit.
// Reset clears the valid bits at once; the memories need no clearing pass.
module keyed_value_table_unit import kvt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned KEY_BYTES     = 8,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  kvt_req_t in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output kvt_res_t out_res
);

  localparam int unsigned KEY_W = KEY_BYTES * 8;
  localparam int unsigned VAL_W = VALUE_BITS;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EXT_W = 3 * VAL_FIELD_W;

  logic                   in_fire;
  logic [KEY_FIELD_W-1:0] key_norm;
  logic [KEY_W-1:0]       req_key;
  logic [EXT_W-1:0]       val_in_ext;
  logic [VAL_W-1:0]       req_val;
  logic                   req_empty;
  logic                   ctrl_busy;
  logic                   out_busy;
  kvt_mem_cmd_t           mem_cmd;
  logic [IDX_W-1:0]       mem_addr;
  logic [KEY_W-1:0]       wr_key;
  logic [VAL_W-1:0]       wr_val;
  logic [KEY_W-1:0]       key_rdata;
  logic [VAL_W-1:0]       val_rdata;
  logic                   res_fire;
  logic [1:0]             res_status;
  logic [VAL_W-1:0]       res_val;
  logic [EXT_W-1:0]       res_val_ext;
  logic                   out_valid_r;
  kvt_res_t               out_res_r;

  // Request decode: cut the key at its end and fit the value to the stored width.
  assign in_fire    = in_valid && !in_stall;
  assign key_norm   = normalize_key(in_req.key, KEY_BYTES);
  assign req_key    = key_norm[KEY_W-1:0];
  assign req_empty  = (key_norm[7:0] == 8'd0);
  assign val_in_ext = {{(EXT_W - VAL_FIELD_W){1'b0}}, in_req.value};
  assign req_val    = val_in_ext[VAL_W-1:0];
  assign in_stall   = ctrl_busy;

  kvt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_W         (KEY_W),
    .VAL_W         (VAL_W),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_go     (in_fire),
    .req_op     (in_req.opcode),
    .req_key    (req_key),
    .req_val    (req_val),
    .req_empty  (req_empty),
    .key_rdata  (key_rdata),
    .val_rdata  (val_rdata),
    .out_busy   (out_busy),
    .ctrl_busy  (ctrl_busy),
    .mem_cmd    (mem_cmd),
    .mem_addr   (mem_addr),
    .wr_key     (wr_key),
    .wr_val     (wr_val),
    .res_fire   (res_fire),
    .res_status (res_status),
    .res_val    (res_val)
  );

  kvt_store #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_W         (KEY_W),
    .VAL_W         (VAL_W),
    .IDX_W         (IDX_W)
  ) u_store (
    .clk       (clk),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .wr_key    (wr_key),
    .wr_val    (wr_val),
    .key_rdata (key_rdata),
    .val_rdata (val_rdata)
  );

  // Output register: holds a result until the receiver takes it.
  assign out_busy    = out_valid_r && out_stall;
  assign res_val_ext = {{(EXT_W - VAL_W){1'b0}}, res_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_res_r.status    <= res_status;
      out_res_r.value_res <= res_val_ext[VAL_FIELD_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef NO_ASSERTIONS
  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> !out_busy)
    else $error("result committed while output register is stalled");

  // The memories are never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_cmd.rd_en |-> !(mem_cmd.key_we || mem_cmd.val_we))
    else $error("memory read and write in the same cycle");

  // Writing a new key always writes its value as well.
  a_insert_pair: assert property (@(posedge clk) disable iff (!rst_n)
    mem_cmd.key_we |-> mem_cmd.val_we)
    else $error("key written without its value");

  // An accepted request always leaves the sequencer busy or firing a result.
  a_fire_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (ctrl_busy && !res_fire) || res_fire)
    else $error("accepted request left the sequencer idle");
`endif

endmodule

>>> rtl/kvt_store.sv
// Key and value memories of the table, one shared synchronous port each.
module kvt_store import kvt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned KEY_W         = 64,
  parameter int unsigned VAL_W         = 32,
  parameter int unsigned IDX_W         = 4
) (
  input  logic               clk,
  input  kvt_mem_cmd_t       mem_cmd,
  input  logic [IDX_W-1:0]   mem_addr,
  input  logic [KEY_W-1:0]   wr_key,
  input  logic [VAL_W-1:0]   wr_val,
  output logic [KEY_W-1:0]   key_rdata,
  output logic [VAL_W-1:0]   val_rdata
);

  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  logic [VAL_W-1:0] val_mem [TABLE_ENTRIES];

  // Key memory: write at the shared address, registered read.
  always_ff @(posedge clk) begin
    if (mem_cmd.key_we) begin
      key_mem[mem_addr] <= wr_key;
    end
    if (mem_cmd.rd_en) begin
      key_rdata <= key_mem[mem_addr];
    end
  end

  // Value memory: same address as the key memory.
  always_ff @(posedge clk) begin
    if (mem_cmd.val_we) begin
      val_mem[mem_addr] <= wr_val;
    end
    if (mem_cmd.rd_en) begin
      val_rdata <= val_mem[mem_addr];
    end
  end

endmodule

>>> rtl/kvt_ctrl.sv
// Request sequencer: scans the entries, tracks match and free slot, commits the update.
module kvt_ctrl import kvt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned KEY_W         = 64,
  parameter int unsigned VAL_W         = 32,
  parameter int unsigned IDX_W         = 4,
  parameter int unsigned CNT_W         = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_go,
  input  logic [1:0]       req_op,
  input  logic [KEY_W-1:0] req_key,
  input  logic [VAL_W-1:0] req_val,
  input  logic             req_empty,
  input  logic [KEY_W-1:0] key_rdata,
  input  logic [VAL_W-1:0] val_rdata,
  input  logic             out_busy,
  output logic             ctrl_busy,
  output kvt_mem_cmd_t     mem_cmd,
  output logic [IDX_W-1:0] mem_addr,
  output logic [KEY_W-1:0] wr_key,
  output logic [VAL_W-1:0] wr_val,
  output logic             res_fire,
  output logic [1:0]       res_status,
  output logic [VAL_W-1:0] res_val
);

  kvt_state_t         state_r, state_nxt;
  logic [1:0]         op_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   val_r;
  logic               empty_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               hit_found_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [VAL_W-1:0]   hit_val_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic               scan_issue;
  logic               scan_last;
  logic               skip_scan;
  logic               hit_now;
  logic               free_now;
  logic               valid_set;
  logic               valid_clr;
  logic               commit_go;

  // Scan bookkeeping: one read issued per cycle until every entry is covered.
  assign scan_issue = (state_r == ST_SCAN) && (cnt_r != CNT_W'(TABLE_ENTRIES));
  assign scan_last  = (state_r == ST_SCAN) && (cnt_r == CNT_W'(TABLE_ENTRIES)) && rd_vld_r;
  assign hit_now    = rd_vld_r && valid_r[rd_idx_r] && (key_rdata == key_r);
  assign free_now   = rd_vld_r && !valid_r[rd_idx_r];
  assign commit_go  = (state_r == ST_COMMIT) && !out_busy;

  // Empty keys and unused opcodes need no scan.
  assign skip_scan  = req_empty || !(req_op == OP_SET || req_op == OP_GET || req_op == OP_DEL);

  assign ctrl_busy  = (state_r != ST_IDLE);
  assign wr_key     = key_r;
  assign wr_val     = val_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_go) begin
          state_nxt = skip_scan ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory commands, valid-bit updates and the result.
  always_comb begin
    mem_cmd    = '0;
    mem_addr   = cnt_r[IDX_W-1:0];
    res_fire   = 1'b0;
    res_status = STAT_NOT_FOUND;
    res_val    = '0;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    case (state_r)
      ST_SCAN: begin
        mem_cmd.rd_en = scan_issue;
      end
      ST_COMMIT: begin
        mem_addr = hit_found_r ? hit_idx_r : free_idx_r;
        res_fire = !out_busy;
        if (empty_r) begin
          res_status = STAT_EMPTY_KEY;
        end else begin
          case (op_r)
            OP_SET: begin
              if (hit_found_r) begin
                mem_cmd.val_we = commit_go;
                res_status     = STAT_OK;
              end else if (free_found_r) begin
                mem_cmd.key_we = commit_go;
                mem_cmd.val_we = commit_go;
                valid_set      = commit_go;
                res_status     = STAT_OK;
              end else begin
                res_status = STAT_FULL;
              end
            end
            OP_GET: begin
              if (hit_found_r) begin
                res_status = STAT_OK;
                res_val    = hit_val_r;
              end
            end
            OP_DEL: begin
              if (hit_found_r) begin
                valid_clr  = commit_go;
                res_status = STAT_OK;
              end
            end
            default: res_status = STAT_NOT_FOUND;
          endcase
        end
      end
      default: begin
        mem_cmd = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      valid_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= scan_issue;
      if (req_go && state_r == ST_IDLE) begin
        cnt_r        <= '0;
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (scan_issue) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (state_r == ST_SCAN && hit_now && !hit_found_r) begin
          hit_found_r <= 1'b1;
        end
        if (state_r == ST_SCAN && free_now && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end
      if (valid_set) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (valid_clr) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  // Request and scan payload registers.
  always_ff @(posedge clk) begin
    if (req_go && state_r == ST_IDLE) begin
      op_r    <= req_op;
      key_r   <= req_key;
      val_r   <= req_val;
      empty_r <= req_empty;
    end
    if (scan_issue) begin
      rd_idx_r <= cnt_r[IDX_W-1:0];
    end
    if (state_r == ST_SCAN && hit_now && !hit_found_r) begin
      hit_idx_r <= rd_idx_r;
      hit_val_r <= val_rdata;
    end
    if (state_r == ST_SCAN && free_now && !free_found_r) begin
      free_idx_r <= rd_idx_r;
    end
  end

endmodule
